[src/w3r_pkg.sv]
// ----------------------------------------------------------------------------
// w3r_pkg
// Shared types and constants for the WENO3 face reconstruction pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package w3r_pkg;

  // Sample format
  localparam int SAMPLE_W = 32;
  localparam int FRAC_W   = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;
  localparam int WEIGHT_W   = 17;
  localparam int SCALE_W    = 21;

  localparam logic [CFG_IDX_W-1:0] REG_PLUS_WEIGHT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MINUS_WEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REF_SCALE    = 2'd2;

  localparam logic [WEIGHT_W-1:0] PLUS_WEIGHT_RST  = 17'd43691;
  localparam logic [WEIGHT_W-1:0] MINUS_WEIGHT_RST = 17'd21845;
  localparam logic [SCALE_W-1:0]  REF_SCALE_RST    = 21'd20480;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE       = 17'd65536;

  // Internal widths
  localparam int DIFF_W  = SAMPLE_W + 1;   // forward / backward difference
  localparam int CURV_W  = SAMPLE_W + 2;   // second difference
  localparam int REF_W   = 37;             // reference scale in sample units
  localparam int SQ_LIM  = 23;             // normalized magnitude width
  localparam int SQ_W    = 2 * SQ_LIM;
  localparam int DEN_W   = SQ_W + 1;
  localparam int NUM_W   = SQ_W + FRAC_W;
  localparam int PPROD_W = 2 * SAMPLE_W;
  localparam int PSUM_W  = SAMPLE_W + 1;
  localparam int SUM_LIM = 46;

  // Pipelined divider geometry
  localparam int DIV_NUM_W = 66;
  localparam int DIV_DEN_W = DEN_W;
  localparam int DIV_Q_W   = 41;
  localparam int DIV_CMP_W = DIV_DEN_W + DIV_Q_W;

  localparam int RATIO_CAP_BIT = 40;

  // Channel payloads
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] prev_cell;
    logic signed [SAMPLE_W-1:0] this_cell;
    logic signed [SAMPLE_W-1:0] next_cell;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] upper_face_value;
    logic signed [SAMPLE_W-1:0] lower_face_value;
  } out_item_t;

  // Front end result, handed to the smoothness dividers
  typedef struct packed {
    logic [NUM_W-1:0]           num;
    logic [DEN_W-1:0]           den0;
    logic [DEN_W-1:0]           den1;
    logic                       zero0;
    logic                       zero1;
    logic                       ovf0;
    logic                       ovf1;
    logic signed [SAMPLE_W-1:0] q0;
    logic signed [DIFF_W-1:0]   dqb;
    logic signed [CURV_W-1:0]   diff;
    logic [PPROD_W-1:0]         pprod;
    logic [PSUM_W-1:0]          psum;
    logic                       pact;
    logic                       pneg;
  } front_t;

endpackage

`default_nettype wire

[src/w3r_div.sv]
// ----------------------------------------------------------------------------
// w3r_div
// Fully pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module w3r_div
  import w3r_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic [DIV_NUM_W-1:0] num,
  input  wire logic [DIV_DEN_W-1:0] den,
  output logic                      out_valid,
  output logic [DIV_Q_W-1:0]        quot
);

  logic [DIV_NUM_W-1:0] rem [DIV_Q_W+1];
  logic [DIV_DEN_W-1:0] dv  [DIV_Q_W+1];
  logic [DIV_Q_W-1:0]   qb  [DIV_Q_W+1];
  logic                 vld [DIV_Q_W+1];

  assign rem[0] = num;
  assign dv[0]  = den;
  assign qb[0]  = '0;
  assign vld[0] = in_valid;

  // Resolve one quotient bit per stage, most significant first
  for (genvar i = 0; i < DIV_Q_W; i++) begin : g_stage
    localparam int K = DIV_Q_W - 1 - i;
    logic [DIV_CMP_W-1:0] sh;
    logic [DIV_CMP_W-1:0] rx;
    logic                 take;

    assign sh   = DIV_CMP_W'(dv[i]) << K;
    assign rx   = DIV_CMP_W'(rem[i]);
    assign take = (rx >= sh);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      dv[i+1]  <= dv[i];
      rem[i+1] <= take ? (rem[i] - sh[DIV_NUM_W-1:0]) : rem[i];
      qb[i+1]  <= qb[i] | (DIV_Q_W'(take) << K);
    end
  end

  assign out_valid = vld[DIV_Q_W];
  assign quot      = qb[DIV_Q_W];

endmodule

`default_nettype wire

[src/w3r_front.sv]
// ----------------------------------------------------------------------------
// w3r_front
// Differences, reference scale, normalization and squares ahead of the
// smoothness dividers (seven register stages).
// ----------------------------------------------------------------------------
`default_nettype none

module w3r_front
  import w3r_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire in_item_t           in_item,
  input  wire logic [SCALE_W-1:0] ref_scale,
  output logic                    out_valid,
  output front_t                  out_data
);

  // Stage 1: capture inputs
  logic     v1;
  in_item_t s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    s1 <= in_item;
  end

  // Stage 2: differences and magnitudes
  logic signed [DIFF_W-1:0] dqf, dqb, ndqf, ndqb;
  logic signed [CURV_W-1:0] diff, ndiff;
  logic signed [SAMPLE_W:0] nqm, nq0, nqp;
  logic [SAMPLE_W-1:0]      mqm, mq0, mqp, mf_c, mb_c, mx_c;
  logic [DIFF_W-1:0]        a_c;

  always_comb begin
    dqf   = DIFF_W'(s1.next_cell) - DIFF_W'(s1.this_cell);
    dqb   = DIFF_W'(s1.this_cell) - DIFF_W'(s1.prev_cell);
    diff  = CURV_W'(dqf) - CURV_W'(dqb);
    ndqf  = -dqf;
    ndqb  = -dqb;
    ndiff = -diff;
    mf_c  = dqf[DIFF_W-1] ? ndqf[SAMPLE_W-1:0] : dqf[SAMPLE_W-1:0];
    mb_c  = dqb[DIFF_W-1] ? ndqb[SAMPLE_W-1:0] : dqb[SAMPLE_W-1:0];
    a_c   = diff[CURV_W-1] ? ndiff[DIFF_W-1:0] : diff[DIFF_W-1:0];
    nqm   = -(DIFF_W'(s1.prev_cell));
    nq0   = -(DIFF_W'(s1.this_cell));
    nqp   = -(DIFF_W'(s1.next_cell));
    mqm   = s1.prev_cell[SAMPLE_W-1] ? nqm[SAMPLE_W-1:0] : s1.prev_cell;
    mq0   = s1.this_cell[SAMPLE_W-1] ? nq0[SAMPLE_W-1:0] : s1.this_cell;
    mqp   = s1.next_cell[SAMPLE_W-1] ? nqp[SAMPLE_W-1:0] : s1.next_cell;
    mx_c  = mq0;
    if (mqm > mx_c) mx_c = mqm;
    if (mqp > mx_c) mx_c = mqp;
  end

  logic                       v2;
  logic signed [SAMPLE_W-1:0] q0_2;
  logic signed [DIFF_W-1:0]   dqf_2, dqb_2;
  logic signed [CURV_W-1:0]   diff_2;
  logic [SAMPLE_W-1:0]        mf_2, mb_2, mx_2;
  logic [DIFF_W-1:0]          a_2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    q0_2   <= s1.this_cell;
    dqf_2  <= dqf;
    dqb_2  <= dqb;
    diff_2 <= diff;
    mf_2   <= mf_c;
    mb_2   <= mb_c;
    mx_2   <= mx_c;
    a_2    <= a_c;
  end

  // Stage 3: reference scale and limiter product
  logic [SCALE_W+SAMPLE_W-1:0] rp;
  logic                        pos_c, neg_c;

  always_comb begin
    rp    = (SCALE_W+SAMPLE_W)'(ref_scale) * (SCALE_W+SAMPLE_W)'(mx_2);
    pos_c = !dqf_2[DIFF_W-1] && (dqf_2 != '0) && !dqb_2[DIFF_W-1] && (dqb_2 != '0);
    neg_c = dqf_2[DIFF_W-1] && dqb_2[DIFF_W-1];
  end

  logic                       v3;
  logic signed [SAMPLE_W-1:0] q0_3;
  logic signed [DIFF_W-1:0]   dqb_3;
  logic signed [CURV_W-1:0]   diff_3;
  logic [SAMPLE_W-1:0]        mf_3, mb_3;
  logic [DIFF_W-1:0]          a_3;
  logic [REF_W-1:0]           r_3;
  logic [PPROD_W-1:0]         pprod_3;
  logic [PSUM_W-1:0]          psum_3;
  logic                       pact_3, pneg_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    q0_3    <= q0_2;
    dqb_3   <= dqb_2;
    diff_3  <= diff_2;
    mf_3    <= mf_2;
    mb_3    <= mb_2;
    a_3     <= a_2;
    r_3     <= rp[SCALE_W+SAMPLE_W-1:FRAC_W];
    pprod_3 <= PPROD_W'(mf_2) * PPROD_W'(mb_2);
    psum_3  <= PSUM_W'(mf_2) + PSUM_W'(mb_2);
    pact_3  <= pos_c || neg_c;
    pneg_3  <= neg_c;
  end

  // Stage 4: largest of the four magnitudes
  logic [REF_W-1:0] big_c;

  always_comb begin
    big_c = REF_W'(a_3);
    if (REF_W'(mf_3) > big_c) big_c = REF_W'(mf_3);
    if (REF_W'(mb_3) > big_c) big_c = REF_W'(mb_3);
    if (r_3 > big_c) big_c = r_3;
  end

  logic                       v4;
  logic signed [SAMPLE_W-1:0] q0_4;
  logic signed [DIFF_W-1:0]   dqb_4;
  logic signed [CURV_W-1:0]   diff_4;
  logic [SAMPLE_W-1:0]        mf_4, mb_4;
  logic [DIFF_W-1:0]          a_4;
  logic [REF_W-1:0]           r_4, big_4;
  logic [PPROD_W-1:0]         pprod_4;
  logic [PSUM_W-1:0]          psum_4;
  logic                       pact_4, pneg_4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    q0_4    <= q0_3;
    dqb_4   <= dqb_3;
    diff_4  <= diff_3;
    mf_4    <= mf_3;
    mb_4    <= mb_3;
    a_4     <= a_3;
    r_4     <= r_3;
    big_4   <= big_c;
    pprod_4 <= pprod_3;
    psum_4  <= psum_3;
    pact_4  <= pact_3;
    pneg_4  <= pneg_3;
  end

  // Stage 5: common normalizing shift
  logic [5:0]       nbits;
  logic [3:0]       sh;
  logic [REF_W-1:0] ta, tf, tg, tr;

  always_comb begin
    nbits = '0;
    for (int i = 0; i < REF_W; i++) begin
      if (big_4[i]) nbits = 6'(i + 1);
    end
    sh = (nbits > 6'(SQ_LIM)) ? 4'(nbits - 6'(SQ_LIM)) : 4'd0;
    ta = REF_W'(a_4) >> sh;
    tf = REF_W'(mf_4) >> sh;
    tg = REF_W'(mb_4) >> sh;
    tr = r_4 >> sh;
  end

  logic                       v5;
  logic signed [SAMPLE_W-1:0] q0_5;
  logic signed [DIFF_W-1:0]   dqb_5;
  logic signed [CURV_W-1:0]   diff_5;
  logic [SQ_LIM-1:0]          an_5, fn_5, gn_5, rn_5;
  logic [PPROD_W-1:0]         pprod_5;
  logic [PSUM_W-1:0]          psum_5;
  logic                       pact_5, pneg_5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    q0_5    <= q0_4;
    dqb_5   <= dqb_4;
    diff_5  <= diff_4;
    an_5    <= ta[SQ_LIM-1:0];
    fn_5    <= tf[SQ_LIM-1:0];
    gn_5    <= tg[SQ_LIM-1:0];
    rn_5    <= tr[SQ_LIM-1:0];
    pprod_5 <= pprod_4;
    psum_5  <= psum_4;
    pact_5  <= pact_4;
    pneg_5  <= pneg_4;
  end

  // Stage 6: squares
  logic                       v6;
  logic signed [SAMPLE_W-1:0] q0_6;
  logic signed [DIFF_W-1:0]   dqb_6;
  logic signed [CURV_W-1:0]   diff_6;
  logic [SQ_W-1:0]            a2_6, f2_6, g2_6, r2_6;
  logic [PPROD_W-1:0]         pprod_6;
  logic [PSUM_W-1:0]          psum_6;
  logic                       pact_6, pneg_6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    q0_6    <= q0_5;
    dqb_6   <= dqb_5;
    diff_6  <= diff_5;
    a2_6    <= SQ_W'(an_5) * SQ_W'(an_5);
    f2_6    <= SQ_W'(fn_5) * SQ_W'(fn_5);
    g2_6    <= SQ_W'(gn_5) * SQ_W'(gn_5);
    r2_6    <= SQ_W'(rn_5) * SQ_W'(rn_5);
    pprod_6 <= pprod_5;
    psum_6  <= psum_5;
    pact_6  <= pact_5;
    pneg_6  <= pneg_5;
  end

  // Stage 7: denominators and quotient overflow check
  logic [DEN_W-1:0]     d0_c, d1_c;
  logic [NUM_W-1:0]     num_c;
  logic [DIV_CMP_W-1:0] lim0, lim1;

  always_comb begin
    d0_c  = DEN_W'(f2_6) + DEN_W'(r2_6);
    d1_c  = DEN_W'(g2_6) + DEN_W'(r2_6);
    num_c = {a2_6, {FRAC_W{1'b0}}};
    lim0  = DIV_CMP_W'(d0_c) << DIV_Q_W;
    lim1  = DIV_CMP_W'(d1_c) << DIV_Q_W;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v6;
    end
    out_data.num   <= num_c;
    out_data.den0  <= d0_c;
    out_data.den1  <= d1_c;
    out_data.zero0 <= (d0_c == '0);
    out_data.zero1 <= (d1_c == '0);
    out_data.ovf0  <= (DIV_CMP_W'(num_c) >= lim0);
    out_data.ovf1  <= (DIV_CMP_W'(num_c) >= lim1);
    out_data.q0    <= q0_6;
    out_data.dqb   <= dqb_6;
    out_data.diff  <= diff_6;
    out_data.pprod <= pprod_6;
    out_data.psum  <= psum_6;
    out_data.pact  <= pact_6;
    out_data.pneg  <= pneg_6;
  end

endmodule

`default_nettype wire

[src/weno3_interface_reconstruct_top.sv]
// ----------------------------------------------------------------------------
// weno3_interface_reconstruct_top
// Third-order WENO face reconstruction of one cell from three cell averages.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive item (prev_cell, this_cell, next_cell) and raise
//   start; the transfer happens at every rising edge with start high and
//   busy low. busy is always low, so one cell may be sent every cycle.
//   Output channel: done is high for exactly one cycle with both face values
//   on result. Results come out in input order.
//   From the accepting edge to the done cycle, a cell passes through the
//   front stages, two chained 41-stage pipelined dividers (smoothness
//   ratio, then nonlinear weight) and the blend stages.
//   Throughput: one cell per cycle, sustained.
//   Configuration: cfg_write with cfg_index and cfg_data writes a register
//   at the clock edge; write only while no cell is in flight.
//   Reset: rst (synchronous) empties the pipeline and loads the default
//   weights and reference scale. The receiver cannot stall, so the pipeline
//   advances every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module weno3_interface_reconstruct_top
  import w3r_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_item_t              item,
  output logic                       done,
  output out_item_t                  result,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ALPHA_W = WEIGHT_W + DIV_Q_W;
  localparam int ASUM_W  = ALPHA_W + 1;
  localparam int PROD_W  = WEIGHT_W + 1 + CURV_W;
  localparam int CTR_W   = SAMPLE_W + 3;
  localparam int FULL_W  = PROD_W + 2;
  localparam int FACE_W  = FULL_W - FRAC_W - 1;

  localparam logic [DIV_Q_W-1:0]       RATIO_CAP = DIV_Q_W'(1) << RATIO_CAP_BIT;
  localparam logic [DIV_Q_W-1:0]       B_ONE     = DIV_Q_W'(1) << FRAC_W;
  localparam logic signed [FULL_W-1:0] ROUND_ONE = FULL_W'(1) << FRAC_W;
  localparam logic signed [FACE_W-1:0] SAT_HI    = FACE_W'({1'b0, {(SAMPLE_W-1){1'b1}}});
  localparam logic signed [FACE_W-1:0] SAT_LO    = -SAT_HI - FACE_W'(1);

  typedef struct packed {
    logic                       zero0;
    logic                       zero1;
    logic                       ovf0;
    logic                       ovf1;
    logic signed [SAMPLE_W-1:0] q0;
    logic signed [DIFF_W-1:0]   dqb;
    logic signed [CURV_W-1:0]   diff;
    logic [PPROD_W-1:0]         pprod;
    logic [PSUM_W-1:0]          psum;
    logic                       pact;
    logic                       pneg;
  } side1_t;

  typedef struct packed {
    logic                       zp;
    logic                       zm;
    logic signed [SAMPLE_W-1:0] q0;
    logic signed [DIFF_W-1:0]   dqb;
    logic signed [CURV_W-1:0]   diff;
    logic                       pact;
    logic                       pneg;
  } side2_t;

  // Configuration registers
  logic [WEIGHT_W-1:0] plus_weight, minus_weight;
  logic [SCALE_W-1:0]  ref_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      plus_weight  <= PLUS_WEIGHT_RST;
      minus_weight <= MINUS_WEIGHT_RST;
      ref_scale    <= REF_SCALE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PLUS_WEIGHT:  plus_weight  <= cfg_data[WEIGHT_W-1:0];
        REG_MINUS_WEIGHT: minus_weight <= cfg_data[WEIGHT_W-1:0];
        REG_REF_SCALE:    ref_scale    <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline never stalls
  assign busy = 1'b0;

  // Front end
  logic   fv;
  front_t fd;

  w3r_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .in_item   (item),
    .ref_scale (ref_scale),
    .out_valid (fv),
    .out_data  (fd)
  );

  // Smoothness ratio dividers
  logic               sv0, sv1_unused_guard;
  logic [DIV_Q_W-1:0] sq0, sq1;

  w3r_div u_div_b0 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fv),
    .num       (DIV_NUM_W'(fd.num)),
    .den       (fd.den0),
    .out_valid (sv0),
    .quot      (sq0)
  );

  w3r_div u_div_b1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fv),
    .num       (DIV_NUM_W'(fd.num)),
    .den       (fd.den1),
    .out_valid (sv1_unused_guard),
    .quot      (sq1)
  );

  // Carry side data alongside the first dividers
  side1_t line1 [DIV_Q_W];

  always_ff @(posedge clk) begin
    line1[0] <= '{zero0: fd.zero0, zero1: fd.zero1, ovf0: fd.ovf0, ovf1: fd.ovf1,
                  q0: fd.q0, dqb: fd.dqb, diff: fd.diff, pprod: fd.pprod,
                  psum: fd.psum, pact: fd.pact, pneg: fd.pneg};
    for (int i = 1; i < DIV_Q_W; i++) begin
      line1[i] <= line1[i-1];
    end
  end

  side1_t sd1;
  assign sd1 = line1[DIV_Q_W-1];

  // Stage 8: smoothness factors with cap and zero-denominator case
  logic [DIV_Q_W-1:0] qc0, qc1;

  always_comb begin
    if (sd1.zero0) qc0 = '0;
    else if (sd1.ovf0 || sq0 > RATIO_CAP) qc0 = RATIO_CAP;
    else qc0 = sq0;
    if (sd1.zero1) qc1 = '0;
    else if (sd1.ovf1 || sq1 > RATIO_CAP) qc1 = RATIO_CAP;
    else qc1 = sq1;
  end

  logic               v8;
  logic [DIV_Q_W-1:0] b0_8, b1_8;
  side1_t             sd8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= sv0 && sv1_unused_guard;
    end
    b0_8 <= B_ONE + qc0;
    b1_8 <= B_ONE + qc1;
    sd8  <= sd1;
  end

  // Stage 9: unnormalized weights for both faces
  logic [WEIGHT_W-1:0] dp, dm;

  always_comb begin
    dp = (plus_weight > WEIGHT_ONE) ? WEIGHT_ONE : plus_weight;
    dm = (minus_weight > WEIGHT_ONE) ? WEIGHT_ONE : minus_weight;
  end

  logic               v9;
  logic [ALPHA_W-1:0] a0p_9, a1p_9, a0m_9, a1m_9;
  side1_t             sd9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else begin
      v9 <= v8;
    end
    a0p_9 <= ALPHA_W'(dp) * ALPHA_W'(b0_8);
    a1p_9 <= ALPHA_W'(WEIGHT_ONE - dp) * ALPHA_W'(b1_8);
    a0m_9 <= ALPHA_W'(dm) * ALPHA_W'(b0_8);
    a1m_9 <= ALPHA_W'(WEIGHT_ONE - dm) * ALPHA_W'(b1_8);
    sd9   <= sd8;
  end

  // Stage 10: weight sums
  logic               v10;
  logic [ALPHA_W-1:0] a0p_10, a1p_10, a0m_10, a1m_10;
  logic [ASUM_W-1:0]  sp_10, sm_10;
  side1_t             sd10;

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else begin
      v10 <= v9;
    end
    a0p_10 <= a0p_9;
    a1p_10 <= a1p_9;
    a0m_10 <= a0m_9;
    a1m_10 <= a1m_9;
    sp_10  <= ASUM_W'(a0p_9) + ASUM_W'(a1p_9);
    sm_10  <= ASUM_W'(a0m_9) + ASUM_W'(a1m_9);
    sd10   <= sd9;
  end

  // Stage 11: common shift that brings each sum below the limit
  logic [5:0] np, nm;

  always_comb begin
    np = '0;
    nm = '0;
    for (int i = 0; i < ASUM_W; i++) begin
      if (sp_10[i]) np = 6'(i + 1);
      if (sm_10[i]) nm = 6'(i + 1);
    end
  end

  logic               v11;
  logic [ALPHA_W-1:0] a0p_11, a1p_11, a0m_11, a1m_11;
  logic [3:0]         tp_11, tm_11;
  side1_t             sd11;

  always_ff @(posedge clk) begin
    if (rst) begin
      v11 <= 1'b0;
    end else begin
      v11 <= v10;
    end
    a0p_11 <= a0p_10;
    a1p_11 <= a1p_10;
    a0m_11 <= a0m_10;
    a1m_11 <= a1m_10;
    tp_11  <= (np > 6'(SUM_LIM)) ? 4'(np - 6'(SUM_LIM)) : 4'd0;
    tm_11  <= (nm > 6'(SUM_LIM)) ? 4'(nm - 6'(SUM_LIM)) : 4'd0;
    sd11   <= sd10;
  end

  // Stage 12: apply shift and re-add
  logic [ALPHA_W-1:0] s0p, s1p, s0m, s1m;
  logic [ALPHA_W-1:0] ssp, ssm;

  always_comb begin
    s0p = a0p_11 >> tp_11;
    s1p = a1p_11 >> tp_11;
    s0m = a0m_11 >> tm_11;
    s1m = a1m_11 >> tm_11;
    ssp = s0p + s1p;
    ssm = s0m + s1m;
  end

  logic               v12;
  logic [NUM_W-1:0]   nump_12, numm_12;
  logic [DEN_W-1:0]   denp_12, denm_12;
  side1_t             sd12;

  always_ff @(posedge clk) begin
    if (rst) begin
      v12 <= 1'b0;
    end else begin
      v12 <= v11;
    end
    nump_12 <= {s0p[SUM_LIM-1:0], {FRAC_W{1'b0}}};
    numm_12 <= {s0m[SUM_LIM-1:0], {FRAC_W{1'b0}}};
    denp_12 <= ssp[DEN_W-1:0];
    denm_12 <= ssm[DEN_W-1:0];
    sd12    <= sd11;
  end

  // Weight and limiter dividers
  logic               wv, wvm, pv;
  logic [DIV_Q_W-1:0] wqp, wqm, pq;

  w3r_div u_div_wp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v12),
    .num       (DIV_NUM_W'(nump_12)),
    .den       (denp_12),
    .out_valid (wv),
    .quot      (wqp)
  );

  w3r_div u_div_wm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v12),
    .num       (DIV_NUM_W'(numm_12)),
    .den       (denm_12),
    .out_valid (wvm),
    .quot      (wqm)
  );

  w3r_div u_div_plm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v12),
    .num       (DIV_NUM_W'(sd12.pprod)),
    .den       (DIV_DEN_W'(sd12.psum)),
    .out_valid (pv),
    .quot      (pq)
  );

  side2_t line2 [DIV_Q_W];

  always_ff @(posedge clk) begin
    line2[0] <= '{zp: (denp_12 == '0), zm: (denm_12 == '0), q0: sd12.q0,
                  dqb: sd12.dqb, diff: sd12.diff, pact: sd12.pact, pneg: sd12.pneg};
    for (int i = 1; i < DIV_Q_W; i++) begin
      line2[i] <= line2[i-1];
    end
  end

  side2_t sd2;
  assign sd2 = line2[DIV_Q_W-1];

  // Stage 13: blend products, face centers, limiter slope
  logic [WEIGHT_W-1:0]      omp, omm;
  logic signed [WEIGHT_W:0] omp_s, omm_s;
  logic signed [CTR_W-1:0]  hpos;

  always_comb begin
    omp   = sd2.zp ? '0 : wqp[WEIGHT_W-1:0];
    omm   = sd2.zm ? '0 : wqm[WEIGHT_W-1:0];
    omp_s = $signed({1'b0, omp});
    omm_s = $signed({1'b0, omm});
    hpos  = $signed({3'b000, pq[SAMPLE_W-1:0]});
  end

  logic                       v13;
  logic signed [PROD_W-1:0]   pu_13, pl_13;
  logic signed [CTR_W-1:0]    cu_13, cl_13, h_13;
  logic signed [SAMPLE_W-1:0] q0_13;

  always_ff @(posedge clk) begin
    if (rst) begin
      v13 <= 1'b0;
    end else begin
      v13 <= wv && wvm && pv;
    end
    pu_13 <= PROD_W'(omp_s) * PROD_W'(sd2.diff);
    pl_13 <= PROD_W'(omm_s) * PROD_W'(sd2.diff);
    cu_13 <= (CTR_W'(sd2.q0) <<< 1) + CTR_W'(sd2.dqb);
    cl_13 <= (CTR_W'(sd2.q0) <<< 1) - CTR_W'(sd2.dqb);
    h_13  <= sd2.pact ? (sd2.pneg ? -hpos : hpos) : '0;
    q0_13 <= sd2.q0;
  end

  // Stage 14: round WENO faces, form limiter faces
  logic signed [FULL_W-1:0] fu, fl;

  always_comb begin
    fu = (FULL_W'(cu_13) <<< FRAC_W) + FULL_W'(pu_13) + ROUND_ONE;
    fl = (FULL_W'(cl_13) <<< FRAC_W) - FULL_W'(pl_13) + ROUND_ONE;
  end

  logic                     v14;
  logic signed [FACE_W-1:0] wu_14, wl_14, mu_14, ml_14;

  always_ff @(posedge clk) begin
    if (rst) begin
      v14 <= 1'b0;
    end else begin
      v14 <= v13;
    end
    wu_14 <= fu[FULL_W-1:FRAC_W+1];
    wl_14 <= fl[FULL_W-1:FRAC_W+1];
    mu_14 <= FACE_W'(q0_13) + FACE_W'(h_13);
    ml_14 <= FACE_W'(q0_13) - FACE_W'(h_13);
  end

  // Stage 15: fall back on negative faces, saturate, present result
  logic signed [FACE_W-1:0] su, sl, xu, xl;

  always_comb begin
    su = wu_14[FACE_W-1] ? mu_14 : wu_14;
    sl = wl_14[FACE_W-1] ? ml_14 : wl_14;
    if (su > SAT_HI) xu = SAT_HI;
    else if (su < SAT_LO) xu = SAT_LO;
    else xu = su;
    if (sl > SAT_HI) xl = SAT_HI;
    else if (sl < SAT_LO) xl = SAT_LO;
    else xl = sl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v14;
    end
    result.upper_face_value <= xu[SAMPLE_W-1:0];
    result.lower_face_value <= xl[SAMPLE_W-1:0];
  end

endmodule

`default_nettype wire

[tb/tb_weno3_interface_reconstruct_top.sv]
// ----------------------------------------------------------------------------
// tb_weno3_interface_reconstruct_top
// Self-checking bench for the WENO3 face reconstruction pipeline: directed
// cell triples from a table, then random triples under several register
// settings, each result compared against a bit-exact face predictor or a typed-in answer.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_weno3_interface_reconstruct_top
  import w3r_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 97;
  localparam int RANDOM_ROWS = 1900;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic signed [31:0] SMAX = 32'sh7fffffff;
  localparam logic signed [31:0] SMIN = 32'sh80000000;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  in_item_t              item;
  logic                  done;
  out_item_t             result;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor copy of the registers
  logic [WEIGHT_W-1:0] plus_w;
  logic [WEIGHT_W-1:0] minus_w;
  logic [SCALE_W-1:0]  scale;

  out_item_t pending_faces[$];
  int        mismatches;
  longint    cycles;

  // directed rows: a cell triple plus an optional typed-in answer
  typedef struct {
    logic signed [31:0] pc;
    logic signed [31:0] tc;
    logic signed [31:0] nc;
    bit                 known;
    logic signed [31:0] up;
    logic signed [31:0] lo;
  } row_t;

  row_t rows[$];

  weno3_interface_reconstruct_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[weno3_interface_reconstruct_top] ERROR");
      $finish;
    end
  end

  function automatic longint unsigned mag(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic int unsigned bitlen(longint unsigned x);
    int unsigned n;
    n = 0;
    while (x != 0) begin
      n++;
      x >>= 1;
    end
    return n;
  endfunction

  function automatic longint unsigned smoothness(longint unsigned a, longint unsigned f,
                                                 longint unsigned r);
    longint unsigned den;
    longint unsigned q;
    den = f * f + r * r;
    if (den == 0) return 64'd65536;
    q = ((a * a) << 16) / den;
    if (q > (64'd1 << 40)) q = 64'd1 << 40;
    return 64'd65536 + q;
  endfunction

  function automatic longint face_weight(longint unsigned d, longint unsigned b0,
                                         longint unsigned b1);
    longint unsigned a0, a1, sum;
    int unsigned n, t;
    t = 0;
    if (d > 64'd65536) d = 64'd65536;
    a0 = d * b0;
    a1 = (64'd65536 - d) * b1;
    n = bitlen(a0 + a1);
    if (n > 46) t = n - 46;
    a0 >>= t;
    a1 >>= t;
    sum = a0 + a1;
    if (sum == 0) return 0;
    return longint'((a0 << 16) / sum);
  endfunction

  // round to nearest, ties up, of full / 2^17
  function automatic longint round17(longint full);
    return (full + 65536) >>> 17;
  endfunction

  function automatic logic signed [31:0] clamp(longint x);
    if (x > longint'(SMAX)) return SMAX;
    if (x < longint'(SMIN)) return SMIN;
    return x[31:0];
  endfunction

  function automatic out_item_t reconstruct(in_item_t c);
    longint qm, q0, qp, dqf, dqb, diff, wp, wm, up, lo, h;
    longint unsigned mx, a, f, g, r, big, b0, b1, mf, mb;
    int unsigned n, s;
    out_item_t o;
    qm = longint'(c.prev_cell);
    q0 = longint'(c.this_cell);
    qp = longint'(c.next_cell);
    dqf = qp - q0;
    dqb = q0 - qm;
    diff = dqf - dqb;
    mx = mag(q0);
    if (mag(qm) > mx) mx = mag(qm);
    if (mag(qp) > mx) mx = mag(qp);
    r = (64'(scale) * mx) >> 16;
    a = mag(diff);
    f = mag(dqf);
    g = mag(dqb);
    big = a;
    if (f > big) big = f;
    if (g > big) big = g;
    if (r > big) big = r;
    n = bitlen(big);
    s = n > 23 ? n - 23 : 0;
    a >>= s; f >>= s; g >>= s; r >>= s;
    b0 = smoothness(a, f, r);
    b1 = smoothness(a, g, r);
    wp = face_weight(64'(plus_w), b0, b1);
    wm = face_weight(64'(minus_w), b0, b1);
    up = round17((2 * q0 + dqb) * 65536 + wp * diff);
    lo = round17((2 * q0 - dqb) * 65536 - wm * diff);
    // harmonic-limited slope for the negative-face fallback
    h = 0;
    if ((dqf > 0 && dqb > 0) || (dqf < 0 && dqb < 0)) begin
      mf = mag(dqf);
      mb = mag(dqb);
      h = longint'((mf * mb) / (mf + mb));
      if (dqf < 0) h = -h;
    end
    if (up < 0) up = q0 + h;
    if (lo < 0) lo = q0 - h;
    o.upper_face_value = clamp(up);
    o.lower_face_value = clamp(lo);
    return o;
  endfunction

  // check every result transfer against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && done) begin
      if (pending_faces.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result);
      end else begin
        want = pending_faces.pop_front();
        if (result.upper_face_value !== want.upper_face_value ||
            result.lower_face_value !== want.lower_face_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("face mismatch: want up %0d lo %0d, got up %0d lo %0d",
                     want.upper_face_value, want.lower_face_value,
                     result.upper_face_value, result.lower_face_value);
        end
      end
    end
  end

  // write one register while the pipeline is empty
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_PLUS_WEIGHT:  plus_w  = WEIGHT_W'(val);
      REG_MINUS_WEIGHT: minus_w = WEIGHT_W'(val);
      REG_REF_SCALE:    scale   = SCALE_W'(val);
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_faces.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // hand one triple over; the gap before it is random when gaps is set
  task automatic send_cell(in_item_t c, bit known, logic signed [31:0] up,
                           logic signed [31:0] lo, bit gaps);
    out_item_t w;
    int        gap;
    gap = gaps ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item  <= c;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    w = reconstruct(c);
    if (known) begin
      w.upper_face_value = up;
      w.lower_face_value = lo;
    end
    pending_faces.push_back(w);
  endtask

  function automatic logic signed [31:0] rand_cell(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000000)) + 32'sd1000);
      2: return $urandom_range(0, 1) ? SMAX - $urandom_range(0, 99) : SMIN + $urandom_range(0, 99);
      default: return 32'(int'($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  task automatic add_row(logic signed [31:0] p, logic signed [31:0] t, logic signed [31:0] n,
                         bit known = 0, logic signed [31:0] up = 0,
                         logic signed [31:0] lo = 0);
    row_t rw;
    rw.pc = p; rw.tc = t; rw.nc = n; rw.known = known; rw.up = up; rw.lo = lo;
    rows.push_back(rw);
  endtask

  initial begin
    in_item_t c;
    int       mode;
    int       phase;
    int unsigned settings[6][3];
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_write = 1'b0;
    cfg_index = REG_PLUS_WEIGHT;
    cfg_data = '0;
    mismatches = 0;
    cycles = 0;
    plus_w = PLUS_WEIGHT_RST;
    minus_w = MINUS_WEIGHT_RST;
    scale = REF_SCALE_RST;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: flat fields first, which give the centre value on both faces
    add_row(0, 0, 0, 1, 0, 0);
    add_row(100, 100, 100, 1, 100, 100);
    add_row(SMAX, SMAX, SMAX, 1, SMAX, SMAX);
    add_row(SMIN, SMIN, SMIN);
    add_row(-5, -5, -5);
    add_row(SMIN, 0, SMAX);
    add_row(SMAX, 0, SMIN);
    add_row(SMIN, SMAX, SMIN);
    add_row(SMAX, SMIN, SMAX);
    add_row(0, 1000, 0);
    add_row(0, 65536, 131072);
    add_row(131072, 65536, 0);
    add_row(10, 0, 10);
    add_row(-1, 0, 1);
    add_row(-1000, 10, 2000);
    add_row(0, 10, 1000000);
    add_row(1000000, 10, 0);
    add_row(SMAX, SMAX - 1, SMAX);
    add_row(32'sh00010000, 32'sh00020000, 32'sh7fff0000);
    add_row(-65536, 65536, -65536);
    add_row(1, 2, 4);
    foreach (rows[i]) begin
      c.prev_cell = rows[i].pc;
      c.this_cell = rows[i].tc;
      c.next_cell = rows[i].nc;
      send_cell(c, rows[i].known, rows[i].up, rows[i].lo, 0);
    end
    start <= 1'b0;
    drain();

    // register settings, extremes included
    settings = '{'{43691, 21845, 20480}, '{0, 0, 0}, '{65536, 65536, 1310720},
                 '{131071, 131071, 2097151}, '{32768, 100, 1}, '{0, 65536, 655360}};
    for (phase = 0; phase < 6; phase++) begin
      write_reg(REG_PLUS_WEIGHT,  settings[phase][0]);
      write_reg(REG_MINUS_WEIGHT, settings[phase][1]);
      write_reg(REG_REF_SCALE,    settings[phase][2]);
      for (int k = 0; k < RANDOM_ROWS / 6; k++) begin
        mode = $urandom_range(0, 3);
        c.prev_cell = rand_cell(mode);
        c.this_cell = rand_cell(mode);
        c.next_cell = rand_cell(mode);
        // long back-to-back runs in some phases
        send_cell(c, 0, 0, 0, phase % 2 == 0 || k % 50 > 25);
        if (k == 100) begin
          start <= 1'b0;
          while (pending_faces.size() != 0) @(posedge clk);
        end
      end
      start <= 1'b0;
      drain();
    end

    if (mismatches == 0 && pending_faces.size() == 0) begin
      $display("[weno3_interface_reconstruct_top] OK");
    end else begin
      $display("[weno3_interface_reconstruct_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
